// ===== src/wav_hp_pkg.sv =====
// Shared types and constants for the WAV header parser.
// Used by the front end, the job queue, the divider back end and the top level.
// No dependencies.
package wav_hp_pkg;

  localparam int unsigned BAUD_W      = 20;
  localparam int unsigned FRAC_BITS   = 8;
  localparam int unsigned SPB_W       = 24;
  localparam int unsigned RATE_W      = 32;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [BAUD_W-1:0] BAUD_RESET = BAUD_W'(1200);
  localparam logic [SPB_W-1:0]  SPB_MAX    = {SPB_W{1'b1}};

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ERR  = 2'd1,
    ST_BITS = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [15:0]       channels;
    logic [RATE_W-1:0] rate_hz;
    logic [15:0]       bits_per_sample;
    logic [SPB_W-1:0]  bit_len;
  } out_t;

  // Parsed header waiting for the back end; bit_len still to compute
  typedef struct packed {
    status_e           status;
    logic [15:0]       channels;
    logic [RATE_W-1:0] rate_hz;
    logic [15:0]       bits_per_sample;
  } job_t;

endpackage

// ===== src/wav_hp_front.sv =====
// Byte-level header walker: tag checks, field capture, job generation.
// Depends on wav_hp_pkg.
module wav_hp_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  wav_hp_pkg::in_t  in_data_i,
  input  logic             queue_full_i,
  output logic             in_stall_o,
  output logic             push_o,
  output wav_hp_pkg::job_t push_job_o
);

  typedef enum logic [3:0] {
    PH_RIFF     = 4'd0,
    PH_RIFFSIZE = 4'd1,
    PH_WAVE     = 4'd2,
    PH_SCANFMT  = 4'd3,
    PH_FMTSIZE  = 4'd4,
    PH_FORMAT   = 4'd5,
    PH_CHANNELS = 4'd6,
    PH_RATE     = 4'd7,
    PH_BYTERATE = 4'd8,
    PH_ALIGN    = 4'd9,
    PH_BITS     = 4'd10,
    PH_SCANDATA = 4'd11,
    PH_DATASIZE = 4'd12
  } phase_e;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  function automatic logic [2:0] field_len(input phase_e ph);
    logic [2:0] len;
    unique case (ph)
      PH_FORMAT, PH_CHANNELS, PH_ALIGN, PH_BITS: len = 3'd2;
      default:                                   len = 3'd4;
    endcase
    return len;
  endfunction

  phase_e                        phase_q, phase_d;
  logic [1:0]                    cnt_q, cnt_d;
  logic [31:0]                   win_q, win_d;
  logic [15:0]                   chan_q, chan_d;
  logic [wav_hp_pkg::RATE_W-1:0] rate_q, rate_d;
  logic [15:0]                   bits_q, bits_d;

  logic        accept;
  logic [31:0] shifted;
  logic        last;

  assign in_stall_o = queue_full_i;
  assign accept     = in_valid_i && !queue_full_i;
  assign shifted    = {win_q[23:0], in_data_i.data_byte};
  assign last       = ({1'b0, cnt_q} + 3'd1) >= field_len(phase_q);

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    win_d   = win_q;
    chan_d  = chan_q;
    rate_d  = rate_q;
    bits_d  = bits_q;
    push_o  = 1'b0;
    // fields become visible only once their phase has been passed
    push_job_o.status          = wav_hp_pkg::ST_ERR;
    push_job_o.channels        = (phase_q > PH_CHANNELS) ? chan_q : '0;
    push_job_o.rate_hz         = (phase_q > PH_RATE) ? rate_q : '0;
    push_job_o.bits_per_sample = (phase_q > PH_BITS) ? bits_q : '0;

    if (accept) begin
      if (in_data_i.end_of_file) begin
        push_o  = 1'b1;
        phase_d = PH_RIFF;
        cnt_d   = '0;
        win_d   = '0;
        chan_d  = '0;
        rate_d  = '0;
        bits_d  = '0;
      end else if (phase_q == PH_SCANFMT || phase_q == PH_SCANDATA) begin
        win_d = shifted;
        if (shifted == ((phase_q == PH_SCANFMT) ? TAG_FMT : TAG_DATA)) begin
          phase_d = phase_e'(4'(phase_q) + 4'd1);
          cnt_d   = '0;
        end
      end else if (4'(phase_q) > 4'(PH_DATASIZE)) begin
        phase_d = PH_RIFF;
        cnt_d   = '0;
        win_d   = '0;
        chan_d  = '0;
        rate_d  = '0;
        bits_d  = '0;
      end else begin
        case (phase_q)
          PH_RIFF, PH_WAVE: win_d = shifted;
          PH_CHANNELS:      chan_d[{cnt_q[0], 3'b000} +: 8] = in_data_i.data_byte;
          PH_RATE:          rate_d[{cnt_q, 3'b000} +: 8] = in_data_i.data_byte;
          PH_BITS:          bits_d[{cnt_q[0], 3'b000} +: 8] = in_data_i.data_byte;
          default:          ;
        endcase

        if (!last) begin
          cnt_d = cnt_q + 2'd1;
        end else begin
          cnt_d = '0;
          if ((phase_q == PH_RIFF && shifted != TAG_RIFF) ||
              (phase_q == PH_WAVE && shifted != TAG_WAVE)) begin
            push_o                     = 1'b1;
            push_job_o.channels        = '0;
            push_job_o.rate_hz         = '0;
            push_job_o.bits_per_sample = '0;
            phase_d = PH_RIFF;
            win_d   = '0;
            chan_d  = '0;
            rate_d  = '0;
            bits_d  = '0;
          end else if (phase_q == PH_DATASIZE) begin
            push_o = 1'b1;
            push_job_o.status = (bits_q == 16'd8 || bits_q == 16'd16) ?
                                wav_hp_pkg::ST_OK : wav_hp_pkg::ST_BITS;
            phase_d = PH_RIFF;
            win_d   = '0;
            chan_d  = '0;
            rate_d  = '0;
            bits_d  = '0;
          end else begin
            phase_d = phase_e'(4'(phase_q) + 4'd1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_RIFF;
      cnt_q   <= '0;
      win_q   <= '0;
      chan_q  <= '0;
      rate_q  <= '0;
      bits_q  <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      win_q   <= win_d;
      chan_q  <= chan_d;
      rate_q  <= rate_d;
      bits_q  <= bits_d;
    end
  end

endmodule

// ===== src/wav_hp_queue.sv =====
// Short register queue of parsed headers between front end and back end.
// Depends on wav_hp_pkg.
module wav_hp_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  wav_hp_pkg::job_t push_job_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             nonempty_o,
  output wav_hp_pkg::job_t head_o
);

  localparam int unsigned DEPTH = wav_hp_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  wav_hp_pkg::job_t entry_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] count_q;

  assign full_o     = (count_q == CNT_W'(DEPTH));
  assign nonempty_o = (count_q != '0);
  assign head_o     = entry_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

endmodule

// ===== src/wav_hp_back.sv =====
// Back end: restoring divider for samples per bit and the output register.
// Depends on wav_hp_pkg.
module wav_hp_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [wav_hp_pkg::BAUD_W-1:0] baud_i,
  input  logic                          job_valid_i,
  input  wav_hp_pkg::job_t              job_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output wav_hp_pkg::out_t              out_data_o
);

  localparam int unsigned NUM_W = wav_hp_pkg::RATE_W + wav_hp_pkg::FRAC_BITS;
  localparam int unsigned DIV_W = wav_hp_pkg::BAUD_W + 1;
  localparam int unsigned CNT_W = $clog2(NUM_W);

  typedef enum logic {
    BK_IDLE,
    BK_DIV
  } back_state_e;

  back_state_e      state_q;
  logic             out_valid_q;
  wav_hp_pkg::out_t out_q;
  wav_hp_pkg::job_t job_q;
  logic [NUM_W-1:0] num_q;
  logic [NUM_W-1:0] quo_q;
  logic [DIV_W-1:0] rem_q;
  logic [CNT_W-1:0] cnt_q;

  logic             out_free;
  logic [DIV_W-1:0] divisor;
  logic [DIV_W:0]   trial;
  logic             qbit;
  logic [NUM_W-1:0] quo_next;
  logic             div_start;
  logic             out_set;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign pop_o       = (state_q == BK_IDLE) && job_valid_i && out_free;
  assign divisor     = {baud_i, 1'b0};
  assign trial       = {rem_q, num_q[NUM_W-1]};
  assign qbit        = (trial >= {1'b0, divisor});
  assign quo_next    = {quo_q[NUM_W-2:0], qbit};
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // divide only for a good header with a nonzero baud
  assign div_start = pop_o && (job_i.status == wav_hp_pkg::ST_OK) && (baud_i != '0);
  assign out_set   = (pop_o && !div_start) || (state_q == BK_DIV && cnt_q == '0);

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
      num_q <= {job_i.rate_hz, {wav_hp_pkg::FRAC_BITS{1'b0}}};
      rem_q <= '0;
    end else if (state_q == BK_DIV) begin
      num_q <= {num_q[NUM_W-2:0], 1'b0};
      rem_q <= qbit ? DIV_W'(trial - {1'b0, divisor}) : trial[DIV_W-1:0];
      quo_q <= quo_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      cnt_q       <= '0;
    end else begin
      if (out_set) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        BK_IDLE: begin
          if (div_start) begin
            state_q <= BK_DIV;
            cnt_q   <= CNT_W'(NUM_W - 1);
          end else if (pop_o) begin
            out_q.status          <= job_i.status;
            out_q.channels        <= job_i.channels;
            out_q.rate_hz         <= job_i.rate_hz;
            out_q.bits_per_sample <= job_i.bits_per_sample;
            out_q.bit_len         <= (job_i.status == wav_hp_pkg::ST_OK) ?
                                     wav_hp_pkg::SPB_MAX : '0;
          end
        end
        BK_DIV: begin
          cnt_q <= cnt_q - CNT_W'(1);
          if (cnt_q == '0) begin
            state_q               <= BK_IDLE;
            out_q.status          <= job_q.status;
            out_q.channels        <= job_q.channels;
            out_q.rate_hz         <= job_q.rate_hz;
            out_q.bits_per_sample <= job_q.bits_per_sample;
            out_q.bit_len         <= (quo_next > NUM_W'(wav_hp_pkg::SPB_MAX)) ?
                                     wav_hp_pkg::SPB_MAX :
                                     quo_next[wav_hp_pkg::SPB_W-1:0];
          end
        end
        default: state_q <= BK_IDLE;
      endcase
    end
  end

endmodule

// ===== src/wav_header_parser_top.sv =====
// WAV header parser top level: baud register, front end, job queue, back end.
// Depends on wav_hp_pkg, wav_hp_front, wav_hp_queue and wav_hp_back.
//
// channel  | handshake              | payload
// ---------+------------------------+------------------------------------------
// in       | in_valid_i / in_stall_o   | wav_hp_pkg::in_t  (byte, end of file)
// out      | out_valid_o / out_stall_i | wav_hp_pkg::out_t (status, fields, spb)
// cfg      | cfg_we_i                  | cfg_wdata_i (baud rate)
//
// Header bytes are taken one per cycle; the front end stalls only when the
// two-entry job queue is full. A result for a good header with nonzero baud
// is computed in the back end one quotient bit per cycle over the 40-bit
// numerator; any other result is registered directly from the popped job.
// Reset restores baud 1200 and an empty pipeline expecting a new "RIFF" tag.
module wav_header_parser_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  wav_hp_pkg::in_t               in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output wav_hp_pkg::out_t              out_data_o,
  input  logic                          cfg_we_i,
  input  logic [wav_hp_pkg::BAUD_W-1:0] cfg_wdata_i
);

  logic [wav_hp_pkg::BAUD_W-1:0] baud_q;
  logic                          push;
  wav_hp_pkg::job_t              push_job;
  logic                          queue_full;
  logic                          queue_nonempty;
  logic                          pop;
  wav_hp_pkg::job_t              head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      baud_q <= wav_hp_pkg::BAUD_RESET;
    end else if (cfg_we_i) begin
      baud_q <= cfg_wdata_i;
    end
  end

  wav_hp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_data_i    (in_data_i),
    .queue_full_i (queue_full),
    .in_stall_o   (in_stall_o),
    .push_o       (push),
    .push_job_o   (push_job)
  );

  wav_hp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .full_o     (queue_full),
    .nonempty_o (queue_nonempty),
    .head_o     (head)
  );

  wav_hp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .baud_i      (baud_q),
    .job_valid_i (queue_nonempty),
    .job_i       (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
